// ===== src/cqc_pkg.sv =====
package cqc_pkg;

  // Result status codes.
  localparam logic [2:0] ST_HIT_OK       = 3'd0;
  localparam logic [2:0] ST_HIT_UNMAPPED = 3'd1;
  localparam logic [2:0] ST_LOAD_OK      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE    = 3'd3;
  localparam logic [2:0] ST_LOAD_RANGE   = 3'd4;

  // Request type codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_HIT  = 1'b1;

  // One channel's coefficients, each signed Q16.16.
  typedef struct packed {
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_l;
    logic signed [31:0] coef_q;
  } coef_t;

  // Largest and smallest signed 48-bit results.
  localparam logic signed [47:0] CAL_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] CAL_MIN = {1'b1, {47{1'b0}}};

endpackage

// ===== src/cqc_if.sv =====
interface cqc_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [3:0]         crate_id;
  logic [4:0]         slot_id;
  logic [4:0]         channel_id;
  logic [15:0]        hit_energy;
  logic signed [31:0] coef_constant;
  logic signed [31:0] coef_linear;
  logic signed [31:0] coef_quadratic;

  modport source (
    output valid, req_type, crate_id, slot_id, channel_id, hit_energy,
           coef_constant, coef_linear, coef_quadratic,
    input  ready
  );
  modport sink (
    input  valid, req_type, crate_id, slot_id, channel_id, hit_energy,
           coef_constant, coef_linear, coef_quadratic,
    output ready
  );
endinterface

interface cqc_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [15:0]        raw_value;
  logic signed [47:0] calibrated_value;
  logic               saturated;

  modport source (
    output valid, status, raw_value, calibrated_value, saturated,
    input  ready
  );
  modport sink (
    input  valid, status, raw_value, calibrated_value, saturated,
    output ready
  );
endinterface

// ===== src/cqc_table.sv =====
// Channel table: a one-bit valid memory that is swept clear after reset and a
// coefficient memory. Both are read at one address with registered data.
module cqc_table
  import cqc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] addr,
  input  logic             wr_en,
  input  coef_t            wr_coef,
  output logic             rd_valid,
  output coef_t            rd_coef,
  output logic             clearing
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  logic       valid_mem [DEPTH];
  coef_t      coef_mem  [DEPTH];
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      valid_mem[addr] <= 1'b1;
    end
    rd_valid <= valid_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[addr] <= wr_coef;
    end
    rd_coef <= coef_mem[addr];
  end

endmodule

// ===== src/channel_quadratic_calibrator.sv =====
// Per-channel quadratic energy calibrator. Each channel, addressed by crate,
// slot and channel, is mapped once by a load transaction that stores its
// signed Q16.16 coefficients c, l and q; a second load to the same channel is
// refused as a duplicate and a load outside the configured crate, slot and
// channel counts is refused as out of range. A hit transaction on a mapped
// channel returns the raw energy e and c + e*(l + q*e) as a signed Q32.16
// value clipped to 48 bits, with a flag when clipping happened; a hit on an
// unmapped or out-of-range channel returns the unmapped status. Every request
// gives exactly one response. The block works on one request at a time and
// is not ready while it does: a load, or a hit on an unmapped or out-of-range
// channel, passes through the registered table read and a decision state, and
// a mapped hit then forms the two products q*e and e*(l + q*e), which take
// turns on one 49 x 17 bit multiplier with an add between them. A finished
// response waits in the output register, and the next request is accepted
// while it waits; a new response is held back while the register still holds
// one that was not taken. The block is ready again in the same cycle the
// response is offered. After reset the valid store is swept clear, one entry
// per cycle, so no request is accepted until every one of its
// NUM_CRATES*NUM_SLOTS*NUM_CHANNELS entries (1024 by default) is clear.
module channel_quadratic_calibrator
  import cqc_pkg::*;
#(
  parameter int NUM_CRATES   = 4,
  parameter int NUM_SLOTS    = 16,
  parameter int NUM_CHANNELS = 16
) (
  input  logic      clk,
  input  logic      rst,
  cqc_req_if.sink   req,
  cqc_rsp_if.source rsp
);

  localparam int DEPTH = NUM_CRATES * NUM_SLOTS * NUM_CHANNELS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_ADD    = 7'b0001000,
    S_MUL2   = 7'b0010000,
    S_SUM    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  // Request held for the length of the transaction.
  logic             is_hit;
  logic             in_range;
  logic [IDX_W-1:0] addr;
  logic [15:0]      energy;
  coef_t            load_coef;

  // Table interface.
  logic  tbl_wr_en;
  logic  tbl_valid;
  coef_t tbl_coef;
  logic  clearing;

  // Shared multiplier and the arithmetic around it.
  logic signed [48:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod;
  logic signed [48:0] inner;
  logic signed [63:0] sum;
  logic               sum_hi;
  logic               sum_lo;

  // Response waiting to be moved into the output register.
  logic [2:0]         res_status;
  logic [15:0]        res_raw;
  logic signed [47:0] res_cal;
  logic               res_sat;

  // Address decode of the incoming request.
  logic             req_in_range;
  logic [IDX_W-1:0] req_addr;
  int               req_idx;

  always_comb begin
    req_in_range = (int'(req.crate_id) < NUM_CRATES) &&
                   (int'(req.slot_id) < NUM_SLOTS) &&
                   (int'(req.channel_id) < NUM_CHANNELS);
    req_idx = (int'(req.crate_id) * NUM_SLOTS + int'(req.slot_id)) * NUM_CHANNELS
              + int'(req.channel_id);
    req_addr = req_in_range ? IDX_W'(req_idx) : '0;
  end

  assign req.ready = (state == S_IDLE) && !clearing;

  cqc_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .addr     (addr),
    .wr_en    (tbl_wr_en),
    .wr_coef  (load_coef),
    .rd_valid (tbl_valid),
    .rd_coef  (tbl_coef),
    .clearing (clearing)
  );

  // A load is stored only when the address is in range and the entry is free.
  assign tbl_wr_en = (state == S_DECIDE) && !is_hit && in_range && !tbl_valid;

  // The multiplier first forms q*e and then e*(l + q*e). The read data stays
  // put through the whole hit, since the address is held and nothing writes.
  assign mul_a    = (state == S_MUL2) ? inner : 49'(tbl_coef.coef_q);
  assign mul_b    = {1'b0, energy};
  assign mul_full = mul_a * mul_b;

  // The final sum fits 64 bits; clip it to the signed 48-bit range.
  assign sum    = prod + 64'(tbl_coef.coef_c);
  assign sum_hi = !sum[63] && (|sum[62:47]);
  assign sum_lo = sum[63] && !(&sum[62:47]);

  always_ff @(posedge clk) begin
    if (state == S_DECIDE || state == S_MUL2) begin
      prod <= mul_full[63:0];
    end
    if (state == S_ADD) begin
      inner <= 49'(tbl_coef.coef_l) + prod[48:0];
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      is_hit    <= (req.req_type == REQ_HIT);
      in_range  <= req_in_range;
      addr      <= req_addr;
      energy    <= req.hit_energy;
      load_coef <= '{coef_c: req.coef_constant,
                     coef_l: req.coef_linear,
                     coef_q: req.coef_quadratic};
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (is_hit && in_range && tbl_valid) begin
            state <= S_ADD;
          end else begin
            state <= S_DONE;
          end
        end
        S_ADD: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response assembly. Anything that is not a mapped hit carries zeros.
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      res_raw <= '0;
      res_cal <= '0;
      res_sat <= 1'b0;
      if (is_hit) begin
        res_status <= (in_range && tbl_valid) ? ST_HIT_OK : ST_HIT_UNMAPPED;
      end else if (!in_range) begin
        res_status <= ST_LOAD_RANGE;
      end else if (tbl_valid) begin
        res_status <= ST_DUPLICATE;
      end else begin
        res_status <= ST_LOAD_OK;
      end
    end else if (state == S_SUM) begin
      res_raw <= energy;
      res_sat <= sum_hi || sum_lo;
      if (sum_hi) begin
        res_cal <= CAL_MAX;
      end else if (sum_lo) begin
        res_cal <= CAL_MIN;
      end else begin
        res_cal <= sum[47:0];
      end
    end
  end

  // Output register; it holds a response until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status           <= res_status;
      rsp.raw_value        <= res_raw;
      rsp.calibrated_value <= res_cal;
      rsp.saturated        <= res_sat;
    end
  end

endmodule

// ===== tb/cqc_checker.sv =====
module cqc_checker
  import cqc_pkg::*;
#(
  parameter int NUM_CRATES   = 4,
  parameter int NUM_SLOTS    = 16,
  parameter int NUM_CHANNELS = 16
) (
  input  logic clk,
  input  logic rst,
  cqc_req_if   req,
  cqc_rsp_if   rsp,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = NUM_CRATES * NUM_SLOTS * NUM_CHANNELS;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        raw;
    logic signed [47:0] cal;
    logic               sat;
  } cal_result_t;

  bit          channel_mapped [TABLE_DEPTH];
  coef_t       channel_coefs  [TABLE_DEPTH];
  cal_result_t pending_results[$];
  cal_result_t want;
  cal_result_t got;
  int          mismatches = 0;

  assign errors = mismatches;

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic cal_result_t calibrate_request(
    input logic        kind,
    input logic [3:0]  crate,
    input logic [4:0]  slot,
    input logic [4:0]  chan,
    input logic [15:0] energy,
    input logic [31:0] cc,
    input logic [31:0] cl,
    input logic [31:0] cq
  );
    cal_result_t r;
    int          idx;
    bit          in_range;
    longint      e;
    longint      c;
    longint      l;
    longint      q;
    longint      sum;
    r        = '0;
    in_range = crate < NUM_CRATES && slot < NUM_SLOTS && chan < NUM_CHANNELS;
    idx      = in_range ? (int'(crate) * NUM_SLOTS + int'(slot)) * NUM_CHANNELS + int'(chan) : 0;
    if (kind == REQ_LOAD) begin
      if (!in_range) begin
        r.status = ST_LOAD_RANGE;
      end else if (channel_mapped[idx]) begin
        r.status = ST_DUPLICATE;
      end else begin
        channel_mapped[idx]       = 1'b1;
        channel_coefs[idx].coef_c = cc;
        channel_coefs[idx].coef_l = cl;
        channel_coefs[idx].coef_q = cq;
        r.status                  = ST_LOAD_OK;
      end
      return r;
    end
    if (!in_range || !channel_mapped[idx]) begin
      r.status = ST_HIT_UNMAPPED;
      return r;
    end
    // The coefficients are Q16.16 and e is an integer, so the sum keeps 16 fraction bits; 64 bits hold it exactly.
    e   = longint'({48'd0, energy});
    c   = longint'($signed(channel_coefs[idx].coef_c));
    l   = longint'($signed(channel_coefs[idx].coef_l));
    q   = longint'($signed(channel_coefs[idx].coef_q));
    sum = c + e * (l + q * e);
    r.status = ST_HIT_OK;
    r.raw    = energy;
    if (sum > longint'(CAL_MAX)) begin
      sum   = longint'(CAL_MAX);
      r.sat = 1'b1;
    end else if (sum < longint'(CAL_MIN)) begin
      sum   = longint'(CAL_MIN);
      r.sat = 1'b1;
    end
    r.cal = sum[47:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input cal_result_t w, input cal_result_t g);
    if (mismatches < 10) begin
      $display("%0t: %s: expected status %0d raw %0d cal %0d sat %0d,",
               $time, what, w.status, w.raw, w.cal, w.sat,
               " got status %0d raw %0d cal %0d sat %0d",
               g.status, g.raw, g.cal, g.sat);
    end
    mismatches++;
  endtask

  // Responses are compared before requests are recorded, so a response that
  // shows up with nothing pending is never matched to a request of the same edge.
  always @(posedge clk) begin
    if (rst) begin
      foreach (channel_mapped[i]) channel_mapped[i] = 1'b0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.raw    = rsp.raw_value;
        got.cal    = rsp.calibrated_value;
        got.sat    = rsp.saturated;
        if (pending_results.size() == 0) begin
          report_mismatch("response with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) report_mismatch("response mismatch", want, got);
        end
      end
      if (req.valid && req.ready) begin
        pending_results = {pending_results,
                           calibrate_request(req.req_type, req.crate_id, req.slot_id,
                                             req.channel_id, req.hit_energy,
                                             req.coef_constant, req.coef_linear,
                                             req.coef_quadratic)};
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top level of the calibrator testbench. It generates clock and reset, drives
// the request channel in bursts, stalls the response channel, and gives the
// final verdict. All prediction and comparison lives in the checker.
module tb
  import cqc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CRATES   = 4;
  localparam int NUM_SLOTS    = 16;
  localparam int NUM_CHANNELS = 16;
  localparam int TABLE_DEPTH  = NUM_CRATES * NUM_SLOTS * NUM_CHANNELS;
  localparam int RANDOM_ITEMS = 1080;
  // The slowest legal run is roughly the clearing sweep plus 1100 transactions;
  // this limit is several times that.
  localparam int CYCLE_LIMIT  = 200000;
  // A mapped hit is the longest transaction, so this is ample.
  localparam int SETTLE_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst;
  int          errors;
  int          outstanding;
  int unsigned cycles = 0;

  // The stimulus keeps its own record of mapped channels so that most hits
  // land on channels that were loaded and therefore exercise the arithmetic.
  bit channel_loaded [TABLE_DEPTH];
  int loaded_list[$];

  cqc_req_if req ();
  cqc_rsp_if rsp ();

  channel_quadratic_calibrator #(
    .NUM_CRATES  (NUM_CRATES),
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  cqc_checker #(
    .NUM_CRATES  (NUM_CRATES),
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver cycles through four stall patterns of equal length: always
  // ready, coin flip, a fixed window in which ready is high while the tick count
  // modulo 7 is below 2, and mostly stalled. Each pattern spans many hits.
  initial begin
    int unsigned tick;
    tick = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case ((tick / 150) % 4)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= 1'($urandom_range(0, 1));
        2:       rsp.ready <= (tick % 7) < 2;
        default: rsp.ready <= $urandom_range(0, 3) == 0;
      endcase
      tick++;
    end
  end

  function automatic bit addr_in_range(input logic [3:0] cr, input logic [4:0] sl,
                                       input logic [4:0] ch);
    return cr < NUM_CRATES && sl < NUM_SLOTS && ch < NUM_CHANNELS;
  endfunction

  // Presents one transaction and returns just after the edge that accepted it.
  // The caller is then free to present the next one or to drop valid.
  task automatic send_req(input logic kind, input logic [3:0] cr, input logic [4:0] sl,
                          input logic [4:0] ch, input logic [15:0] en,
                          input logic [31:0] cc, input logic [31:0] cl,
                          input logic [31:0] cq);
    int idx;
    if (kind == REQ_LOAD && addr_in_range(cr, sl, ch)) begin
      idx = (int'(cr) * NUM_SLOTS + int'(sl)) * NUM_CHANNELS + int'(ch);
      if (!channel_loaded[idx]) begin
        channel_loaded[idx] = 1'b1;
        loaded_list = {loaded_list, idx};
      end
    end
    req.valid          <= 1'b1;
    req.req_type       <= kind;
    req.crate_id       <= cr;
    req.slot_id        <= sl;
    req.channel_id     <= ch;
    req.hit_energy     <= en;
    req.coef_constant  <= cc;
    req.coef_linear    <= cl;
    req.coef_quadratic <= cq;
    do @(posedge clk); while (!req.ready);
  endtask

  // Holds the request channel idle until every pending response has come back.
  task automatic drain_responses();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic void split_index(input int idx, output logic [3:0] cr,
                                      output logic [4:0] sl, output logic [4:0] ch);
    cr = 4'(idx / (NUM_SLOTS * NUM_CHANNELS));
    sl = 5'((idx / NUM_CHANNELS) % NUM_SLOTS);
    ch = 5'(idx % NUM_CHANNELS);
  endfunction

  // An address with at least one coordinate past its configured count; the
  // others span their whole field so every address bit toggles.
  function automatic void pick_outside(output logic [3:0] cr, output logic [4:0] sl,
                                       output logic [4:0] ch);
    cr = 4'($urandom_range(0, 15));
    sl = 5'($urandom_range(0, 31));
    ch = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 2))
      0:       cr = 4'($urandom_range(NUM_CRATES, 15));
      1:       sl = 5'($urandom_range(NUM_SLOTS, 31));
      default: ch = 5'($urandom_range(NUM_CHANNELS, 31));
    endcase
  endfunction

  function automatic void pick_inside(output logic [3:0] cr, output logic [4:0] sl,
                                      output logic [4:0] ch);
    split_index($urandom_range(0, TABLE_DEPTH - 1), cr, sl, ch);
  endfunction

  // Energies lean toward the ends of the range and toward single set bits.
  function automatic logic [15:0] pick_energy();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      2:       return 16'($urandom_range(0, 15));
      3:       return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // A wild coefficient uses the full 32-bit range and mostly drives the result
  // into clipping; a tame one is a symmetric value span_bits wide, chosen so
  // that the calibrated value stays within 48 bits.
  function automatic logic [31:0] pick_coef(input bit wild, input int span_bits);
    if (wild) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        default: return $urandom();
      endcase
    end
    return $urandom_range(0, (1 << span_bits) - 1) - (1 << (span_bits - 1));
  endfunction

  initial begin
    logic [3:0]  cr;
    logic [4:0]  sl;
    logic [4:0]  ch;
    logic [15:0] en;
    logic [31:0] cc;
    logic [31:0] cl;
    logic [31:0] cq;
    logic        kind;
    bit          wild;
    int          burst_left;
    int          gap;
    int          pick;

    rst                <= 1'b1;
    req.valid          <= 1'b0;
    req.req_type       <= REQ_LOAD;
    req.crate_id       <= '0;
    req.slot_id        <= '0;
    req.channel_id     <= '0;
    req.hit_energy     <= '0;
    req.coef_constant  <= '0;
    req.coef_linear    <= '0;
    req.coef_quadratic <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The block sweeps its valid store after reset, so the
    // first transaction simply waits for ready.

    // Hits before anything is mapped, in range and with every address bit set.
    send_req(REQ_HIT, 4'd0, 5'd0, 5'd0, 16'hFFFF, '0, '0, '0);
    send_req(REQ_HIT, 4'd15, 5'd31, 5'd31, 16'h1234, '0, '0, '0);
    // Loads refused for a crate just past the end and for the all-ones address.
    send_req(REQ_LOAD, 4'(NUM_CRATES), 5'd0, 5'd0, '0, 32'h0001_0000, '0, '0);
    send_req(REQ_LOAD, 4'd15, 5'd31, 5'd31, '0, '1, '1, '1);
    // Unity gain on the first channel, then a duplicate that must not overwrite it.
    send_req(REQ_LOAD, 4'd0, 5'd0, 5'd0, '0, 32'h0001_0000, 32'h0001_0000, 32'h0);
    send_req(REQ_LOAD, 4'd0, 5'd0, 5'd0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(REQ_HIT, 4'd0, 5'd0, 5'd0, 16'h0000, '0, '0, '0);
    send_req(REQ_HIT, 4'd0, 5'd0, 5'd0, 16'h0001, '0, '0, '0);
    send_req(REQ_HIT, 4'd0, 5'd0, 5'd0, 16'hFFFF, '0, '0, '0);
    // A channel number past the end must not alias onto the first channel.
    send_req(REQ_HIT, 4'd0, 5'd0, 5'(NUM_CHANNELS), 16'h0100, '0, '0, '0);
    // Largest coefficients on the last entry: clips high at full energy, not at zero energy.
    send_req(REQ_LOAD, 4'(NUM_CRATES - 1), 5'(NUM_SLOTS - 1), 5'(NUM_CHANNELS - 1), '0,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(REQ_HIT, 4'(NUM_CRATES - 1), 5'(NUM_SLOTS - 1), 5'(NUM_CHANNELS - 1), 16'hFFFF,
             '0, '0, '0);
    send_req(REQ_HIT, 4'(NUM_CRATES - 1), 5'(NUM_SLOTS - 1), 5'(NUM_CHANNELS - 1), 16'h0000,
             '0, '0, '0);
    // Most negative coefficients clip low.
    send_req(REQ_LOAD, 4'(NUM_CRATES - 1), 5'd0, 5'(NUM_CHANNELS - 1), '0,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_req(REQ_HIT, 4'(NUM_CRATES - 1), 5'd0, 5'(NUM_CHANNELS - 1), 16'hFFFF, '0, '0, '0);
    // At full energy, q = 0.5, l = 1 + 2^-16 and c = -0.5 give exactly the
    // largest 48-bit value; one more LSB of c clips by one. Negated l and q with
    // c = 0.5 - 2^-16 give exactly the smallest value, and one LSB less clips.
    send_req(REQ_LOAD, 4'd2, 5'd5, 5'd9, '0, -32'sd32768, 32'sd65537, 32'sd32768);
    send_req(REQ_LOAD, 4'd2, 5'd5, 5'd10, '0, -32'sd32767, 32'sd65537, 32'sd32768);
    send_req(REQ_LOAD, 4'd2, 5'd6, 5'd0, '0, 32'sd32767, -32'sd65537, -32'sd32768);
    send_req(REQ_LOAD, 4'd2, 5'd6, 5'd1, '0, 32'sd32766, -32'sd65537, -32'sd32768);
    send_req(REQ_HIT, 4'd2, 5'd5, 5'd9, 16'hFFFF, '0, '0, '0);
    send_req(REQ_HIT, 4'd2, 5'd5, 5'd10, 16'hFFFF, '0, '0, '0);
    send_req(REQ_HIT, 4'd2, 5'd6, 5'd0, 16'hFFFF, '0, '0, '0);
    send_req(REQ_HIT, 4'd2, 5'd6, 5'd1, 16'hFFFF, '0, '0, '0);

    // Let the directed transactions finish before the random traffic starts.
    drain_responses();

    // Random part: about one transaction in five is a load, the rest are hits,
    // and most hits target channels that have been loaded.
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        drain_responses();
      end else if (burst_left <= 0) begin
        // A zero gap keeps valid high across the burst boundary.
        gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 9);
        if (gap != 0) begin
          req.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;

      en   = pick_energy();
      wild = $urandom_range(0, 9) < 4;
      cc   = pick_coef(wild, 26);
      cl   = pick_coef(wild, 20);
      cq   = pick_coef(wild, 10);
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 20) begin
        kind = REQ_LOAD;
        if (pick < 2) begin
          pick_outside(cr, sl, ch);
        end else if (pick == 2 && loaded_list.size() != 0) begin
          split_index(loaded_list[$urandom_range(0, loaded_list.size() - 1)], cr, sl, ch);
        end else begin
          pick_inside(cr, sl, ch);
        end
      end else begin
        kind = REQ_HIT;
        if (pick == 0) begin
          pick_outside(cr, sl, ch);
        end else if (pick == 1 || loaded_list.size() == 0) begin
          pick_inside(cr, sl, ch);
        end else begin
          split_index(loaded_list[$urandom_range(0, loaded_list.size() - 1)], cr, sl, ch);
        end
      end
      send_req(kind, cr, sl, ch, en, cc, cl, cq);
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cqc_pkg.sv
src/cqc_if.sv
src/cqc_table.sv
src/channel_quadratic_calibrator.sv
tb/cqc_checker.sv
tb/tb.sv
